/* hdl/bsp_pkg.sv */
// Shared types, codes and helpers for the bencode stream parser.
// No dependencies; every other file uses it by scoped names.
package bsp_pkg;

	localparam int STACK_DEPTH_DEF = 32;

	localparam int TDATA_W = 104;
	localparam int TUSER_W = 7;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	localparam logic REG_MAX_STR_LEN = 1'b0;
	localparam logic [15:0] MAX_STR_LEN_RST = 16'd256;

	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_L     = 8'h6c;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [63:0] INT_LIM = 64'd922337203685477580;
	localparam logic [20:0] LEN_SAT = 21'h10000;

	localparam logic [1:0] MARK_LIST = 2'd1;
	localparam logic [1:0] MARK_KEY  = 2'd2;
	localparam logic [1:0] MARK_VAL  = 2'd3;

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_INT_OPEN = 3'd1;
	localparam logic [2:0] PH_INT_SIGN = 3'd2;
	localparam logic [2:0] PH_INT_DIG  = 3'd3;
	localparam logic [2:0] PH_STR_LEN  = 3'd4;
	localparam logic [2:0] PH_STR_BODY = 3'd5;

	localparam logic [3:0] EV_NONE       = 4'd0;
	localparam logic [3:0] EV_DICT_START = 4'd1;
	localparam logic [3:0] EV_LIST_START = 4'd2;
	localparam logic [3:0] EV_KEY        = 4'd3;
	localparam logic [3:0] EV_DICT_VAL   = 4'd4;
	localparam logic [3:0] EV_LIST_ELT   = 4'd5;
	localparam logic [3:0] EV_TOP_VAL    = 4'd6;
	localparam logic [3:0] EV_LIST_END   = 4'd7;
	localparam logic [3:0] EV_DICT_END   = 4'd8;
	localparam logic [3:0] EV_STR_BYTE   = 4'd9;
	localparam logic [3:0] EV_OK         = 4'd10;
	localparam logic [3:0] EV_ERROR      = 4'd11;

	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_INT    = 3'd1;
	localparam logic [2:0] KIND_STRING = 3'd2;
	localparam logic [2:0] KIND_LIST   = 3'd3;
	localparam logic [2:0] KIND_DICT   = 3'd4;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
	localparam logic [2:0] ERR_TOO_DEEP  = 3'd4;
	localparam logic [2:0] ERR_SYNTAX    = 3'd5;
	localparam logic [2:0] ERR_UNCLOSED  = 3'd6;
	localparam logic [2:0] ERR_TRUNCATED = 3'd7;

	localparam logic [1:0] STK_HOLD = 2'd0;
	localparam logic [1:0] STK_PUSH = 2'd1;
	localparam logic [1:0] STK_POP  = 2'd2;
	localparam logic [1:0] STK_SET  = 2'd3;

	localparam logic [1:0] CELL_HOLD  = 2'd0;
	localparam logic [1:0] CELL_ABOVE = 2'd1;
	localparam logic [1:0] CELL_BELOW = 2'd2;

	typedef struct packed {
		logic [3:0]        event_res;
		logic [2:0]        value_kind;
		logic signed [63:0] int_value;
		logic [15:0]       string_length;
		logic [7:0]        body_byte;
		logic [2:0]        error_code;
		logic [5:0]        nest_depth;
		logic              last_of_run;
	} res_t;

	typedef struct packed {
		logic [1:0]       n;
		res_t [2:0]       slot;
	} bundle_t;

	function automatic res_t mk_res(input logic [3:0] ev, input logic [2:0] kind,
			input logic [63:0] ival, input logic [15:0] slen, input logic [7:0] bb,
			input logic [5:0] depth);
		res_t r;
		r.event_res     = ev;
		r.value_kind    = kind;
		r.int_value     = ival;
		r.string_length = slen;
		r.body_byte     = bb;
		r.error_code    = ERR_NONE;
		r.nest_depth    = depth;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	function automatic res_t mk_err(input logic [2:0] code, input logic [5:0] depth);
		res_t r;
		r            = mk_res(EV_ERROR, KIND_NONE, 64'd0, 16'd0, 8'd0, depth);
		r.error_code = code;
		return r;
	endfunction

endpackage

/* hdl/bsp_stack_cell.sv */
// One cell of the shifting nesting stack: holds a single 2-bit mark.
// Depends on bsp_pkg for the cell operation codes.
module bsp_stack_cell (
	input  logic       clk,
	input  logic [1:0] op,
	input  logic [1:0] from_above,
	input  logic [1:0] from_below,
	output logic [1:0] mark_q
);

	always_ff @(posedge clk) begin
		case (op)
			bsp_pkg::CELL_ABOVE: mark_q <= from_above;
			bsp_pkg::CELL_BELOW: mark_q <= from_below;
			default:             mark_q <= mark_q;
		endcase
	end

endmodule

/* hdl/bsp_out_queue.sv */
// Result queue: holds result bundles of one byte each and hands out one result per item.
// Depends on bsp_pkg for the bundle and result types.
module bsp_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bsp_pkg::bundle_t bundle_in,
	output logic             space,
	output logic             out_valid,
	input  logic             out_ready,
	output bsp_pkg::res_t    out_res
);

	bsp_pkg::bundle_t                entry_q [bsp_pkg::Q_DEPTH];
	logic [bsp_pkg::Q_PTR_W-1:0]     wr_q;
	logic [bsp_pkg::Q_PTR_W-1:0]     rd_q;
	logic [bsp_pkg::Q_CNT_W-1:0]     fill_q;
	logic [1:0]                      sub_q;
	bsp_pkg::bundle_t                head;
	logic                            pop_item;
	logic                            pop_bundle;

	assign head       = entry_q[rd_q];
	assign out_valid  = (fill_q != '0);
	assign out_res    = head.slot[sub_q];
	assign space      = (fill_q != bsp_pkg::Q_CNT_W'(bsp_pkg::Q_DEPTH));
	assign pop_item   = out_valid && out_ready;
	assign pop_bundle = pop_item && (sub_q == 2'(head.n - 2'd1));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= bundle_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
			sub_q  <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop_bundle) begin
				rd_q  <= rd_q + 1'b1;
				sub_q <= '0;
			end else if (pop_item) begin
				sub_q <= sub_q + 2'd1;
			end
			if (push && !pop_bundle) begin
				fill_q <= fill_q + 1'b1;
			end else if (!push && pop_bundle) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/bencode_stream_parser.sv */
// Bencode stream parser top level: lexer, nesting stack of cells, result queue, APB register.
// Depends on bsp_pkg, bsp_stack_cell and bsp_out_queue.
//
// Usage: one message byte per input item on s_tvalid/s_tready/s_tdata, s_tlast set on
// the final byte of a message. Each byte yields zero to three result items on the
// m_ channel; m_tlast marks the last result of a byte. Results carry the event code
// and value kind in m_tuser and the value, length, body byte, error code and depth
// in m_tdata.
// Throughput: one byte per cycle while the receiver takes one result per cycle; a
// byte that yields n results holds the output until all n are taken. Each byte's results
// are registered into the result queue on acceptance, behind any results still held. The
// lexer updates its state in the accept cycle, so nothing limits input rate but the
// two-bundle result queue; s_tready drops only when that queue is full.
// The nesting stack is a row of STACK_DEPTH cells that shift on push and pop.
// After an error, bytes are swallowed without results up to and including the final byte.
// Reset: lexer idle, stack empty, max_string_length 256, queue empty. A stalled
// receiver holds the current result; input is still taken until the queue fills.
module bencode_stream_parser #(
	parameter int STACK_DEPTH = bsp_pkg::STACK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // data_byte
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// int_value[63:0], string_length[79:64], body_byte[87:80], error_code[90:88],
	// nest_depth[96:91], zero fill above
	output logic [bsp_pkg::TDATA_W-1:0] m_tdata,
	output logic [bsp_pkg::TUSER_W-1:0] m_tuser,   // event_res[3:0], value_kind[6:4]
	output logic                        m_tlast,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);

	function automatic logic [5:0] dep(input logic [CNT_W-1:0] c);
		return 6'(32'(c));
	endfunction

	logic [CNT_W-1:0] cnt_q, cnt_n, cc;
	logic [2:0]       ph_q, ph_n;
	logic [63:0]      acc_q, acc_n, acc_x10;
	logic             neg_q, neg_n;
	logic [16:0]      len_q, len_n;
	logic [20:0]      len_x10;
	logic [15:0]      body_q, body_n;
	logic             err_q, err_set;
	logic [15:0]      max_q;

	logic [1:0]       mark_q [STACK_DEPTH];
	logic [1:0]       cell_op [STACK_DEPTH];
	logic [1:0]       stk_op;
	logic [1:0]       new_top;
	logic [1:0]       top_mark, second_mark, ct;

	logic             accept, full, dig;
	logic [7:0]       b;
	logic [3:0]       d;

	logic             va, vb, vf;
	bsp_pkg::res_t    res_a, res_b, res_f, rc;
	logic             cmp_go, cmp_pop, cmp_second, cmp_str;
	logic [2:0]       cmp_kind;
	logic [63:0]      cmp_ival;
	logic [15:0]      cmp_slen;

	bsp_pkg::bundle_t bundle;
	logic             q_space;
	bsp_pkg::res_t    out_res;

	assign accept      = s_tvalid && s_tready;
	assign s_tready    = q_space;
	assign b           = s_tdata;
	assign dig         = b inside {[bsp_pkg::CH_ZERO:bsp_pkg::CH_NINE]};
	assign d           = dig ? 4'(b - bsp_pkg::CH_ZERO) : 4'd0;
	assign full        = (cnt_q == CNT_W'(STACK_DEPTH));
	assign top_mark    = mark_q[0];
	assign second_mark = mark_q[1];
	assign acc_x10     = (acc_q << 3) + (acc_q << 1);
	assign len_x10     = (21'(len_q) << 3) + (21'(len_q) << 1) + 21'(d);

	always_comb begin
		ph_n       = ph_q;
		acc_n      = acc_q;
		neg_n      = neg_q;
		len_n      = len_q;
		body_n     = body_q;
		cnt_n      = cnt_q;
		err_set    = 1'b0;
		stk_op     = bsp_pkg::STK_HOLD;
		new_top    = top_mark;
		va         = 1'b0;
		vb         = 1'b0;
		vf         = 1'b0;
		res_a      = '0;
		res_b      = '0;
		res_f      = '0;
		rc         = '0;
		cc         = cnt_q;
		ct         = top_mark;
		cmp_go     = 1'b0;
		cmp_pop    = 1'b0;
		cmp_second = 1'b0;
		cmp_str    = 1'b0;
		cmp_kind   = bsp_pkg::KIND_NONE;
		cmp_ival   = '0;
		cmp_slen   = '0;
		if (!err_q) begin
			case (ph_q)
				bsp_pkg::PH_IDLE: begin
					if (b == bsp_pkg::CH_I) begin
						ph_n  = bsp_pkg::PH_INT_OPEN;
						acc_n = '0;
						neg_n = 1'b0;
					end else if (dig) begin
						ph_n  = bsp_pkg::PH_STR_LEN;
						len_n = 17'(d);
					end else if (b == bsp_pkg::CH_L || b == bsp_pkg::CH_D) begin
						if (full) begin
							va      = 1'b1;
							res_a   = bsp_pkg::mk_err(bsp_pkg::ERR_TOO_DEEP, dep(cnt_q));
							err_set = 1'b1;
						end else begin
							stk_op  = bsp_pkg::STK_PUSH;
							new_top = (b == bsp_pkg::CH_L) ? bsp_pkg::MARK_LIST
								: bsp_pkg::MARK_KEY;
							cnt_n   = cnt_q + 1'b1;
							va      = 1'b1;
							res_a   = bsp_pkg::mk_res(
								(b == bsp_pkg::CH_L) ? bsp_pkg::EV_LIST_START
									: bsp_pkg::EV_DICT_START,
								(b == bsp_pkg::CH_L) ? bsp_pkg::KIND_LIST
									: bsp_pkg::KIND_DICT,
								64'd0, 16'd0, 8'd0, dep(cnt_n));
						end
					end else if (b == bsp_pkg::CH_E) begin
						if (cnt_q == '0 || !(top_mark == bsp_pkg::MARK_LIST
								|| top_mark == bsp_pkg::MARK_KEY)) begin
							va      = 1'b1;
							res_a   = bsp_pkg::mk_err(bsp_pkg::ERR_SYNTAX, dep(cnt_q));
							err_set = 1'b1;
						end else begin
							stk_op     = bsp_pkg::STK_POP;
							cnt_n      = cnt_q - 1'b1;
							new_top    = second_mark;
							cmp_kind   = (top_mark == bsp_pkg::MARK_LIST)
								? bsp_pkg::KIND_LIST : bsp_pkg::KIND_DICT;
							va         = 1'b1;
							res_a      = bsp_pkg::mk_res(
								(top_mark == bsp_pkg::MARK_LIST) ? bsp_pkg::EV_LIST_END
									: bsp_pkg::EV_DICT_END,
								cmp_kind, 64'd0, 16'd0, 8'd0, dep(cnt_n));
							cmp_go     = 1'b1;
							cmp_pop    = 1'b1;
							cmp_second = 1'b1;
						end
					end else begin
						va      = 1'b1;
						res_a   = bsp_pkg::mk_err(bsp_pkg::ERR_SYNTAX, dep(cnt_q));
						err_set = 1'b1;
					end
				end
				bsp_pkg::PH_INT_OPEN, bsp_pkg::PH_INT_SIGN: begin
					if (ph_q == bsp_pkg::PH_INT_OPEN && b == bsp_pkg::CH_MINUS) begin
						neg_n = 1'b1;
						ph_n  = bsp_pkg::PH_INT_SIGN;
					end else if (dig) begin
						acc_n = 64'(d);
						ph_n  = bsp_pkg::PH_INT_DIG;
					end else begin
						va      = 1'b1;
						res_a   = bsp_pkg::mk_err(bsp_pkg::ERR_BAD_CHAR, dep(cnt_q));
						err_set = 1'b1;
					end
				end
				bsp_pkg::PH_INT_DIG: begin
					if (dig) begin
						if (acc_q > bsp_pkg::INT_LIM
								|| (acc_q == bsp_pkg::INT_LIM && d > 4'd7)) begin
							va      = 1'b1;
							res_a   = bsp_pkg::mk_err(bsp_pkg::ERR_OVERFLOW, dep(cnt_q));
							err_set = 1'b1;
						end else begin
							acc_n = acc_x10 + 64'(d);
						end
					end else if (b == bsp_pkg::CH_E) begin
						ph_n     = bsp_pkg::PH_IDLE;
						cmp_go   = 1'b1;
						cmp_kind = bsp_pkg::KIND_INT;
						cmp_ival = neg_q ? (64'd0 - acc_q) : acc_q;
					end else begin
						va      = 1'b1;
						res_a   = bsp_pkg::mk_err(bsp_pkg::ERR_BAD_CHAR, dep(cnt_q));
						err_set = 1'b1;
					end
				end
				bsp_pkg::PH_STR_LEN: begin
					if (dig) begin
						len_n = (len_x10 > bsp_pkg::LEN_SAT) ? 17'(bsp_pkg::LEN_SAT)
							: len_x10[16:0];
					end else if (b == bsp_pkg::CH_COLON) begin
						if (len_q > {1'b0, max_q}) begin
							va      = 1'b1;
							res_a   = bsp_pkg::mk_err(bsp_pkg::ERR_TOO_LONG, dep(cnt_q));
							err_set = 1'b1;
						end else if (len_q == '0) begin
							ph_n     = bsp_pkg::PH_IDLE;
							cmp_go   = 1'b1;
							cmp_str  = 1'b1;
							cmp_kind = bsp_pkg::KIND_STRING;
						end else begin
							body_n = len_q[15:0];
							ph_n   = bsp_pkg::PH_STR_BODY;
						end
					end else begin
						va      = 1'b1;
						res_a   = bsp_pkg::mk_err(bsp_pkg::ERR_BAD_CHAR, dep(cnt_q));
						err_set = 1'b1;
					end
				end
				bsp_pkg::PH_STR_BODY: begin
					va    = 1'b1;
					res_a = bsp_pkg::mk_res(bsp_pkg::EV_STR_BYTE, bsp_pkg::KIND_STRING,
						64'd0, 16'd0, b, dep(cnt_q));
					if (body_q != '0) begin
						body_n = body_q - 16'd1;
					end
					if (body_n == '0) begin
						ph_n       = bsp_pkg::PH_IDLE;
						cmp_go     = 1'b1;
						cmp_second = 1'b1;
						cmp_str    = 1'b1;
						cmp_kind   = bsp_pkg::KIND_STRING;
						cmp_slen   = len_q[15:0];
					end
				end
				default: begin
					ph_n    = bsp_pkg::PH_IDLE;
					va      = 1'b1;
					res_a   = bsp_pkg::mk_err(bsp_pkg::ERR_SYNTAX, dep(cnt_q));
					err_set = 1'b1;
				end
			endcase

			if (cmp_go) begin
				cc = cmp_pop ? (cnt_q - 1'b1) : cnt_q;
				ct = cmp_pop ? second_mark : top_mark;
				if (cmp_str && cc != '0 && ct == bsp_pkg::MARK_KEY) begin
					new_top = bsp_pkg::MARK_VAL;
					if (!cmp_pop) begin
						stk_op = bsp_pkg::STK_SET;
					end
					rc = bsp_pkg::mk_res(bsp_pkg::EV_KEY, bsp_pkg::KIND_STRING,
						64'd0, cmp_slen, 8'd0, dep(cc));
				end else if (cc == '0) begin
					rc = bsp_pkg::mk_res(bsp_pkg::EV_TOP_VAL, cmp_kind,
						cmp_ival, cmp_slen, 8'd0, dep(cc));
				end else if (ct == bsp_pkg::MARK_LIST) begin
					rc = bsp_pkg::mk_res(bsp_pkg::EV_LIST_ELT, cmp_kind,
						cmp_ival, cmp_slen, 8'd0, dep(cc));
				end else if (ct == bsp_pkg::MARK_VAL) begin
					new_top = bsp_pkg::MARK_KEY;
					if (!cmp_pop) begin
						stk_op = bsp_pkg::STK_SET;
					end
					rc = bsp_pkg::mk_res(bsp_pkg::EV_DICT_VAL, cmp_kind,
						cmp_ival, cmp_slen, 8'd0, dep(cc));
				end else begin
					rc      = bsp_pkg::mk_err(bsp_pkg::ERR_SYNTAX, dep(cc));
					err_set = 1'b1;
				end
				if (cmp_second) begin
					vb    = 1'b1;
					res_b = rc;
				end else begin
					va    = 1'b1;
					res_a = rc;
				end
			end

			if (s_tlast && !err_set) begin
				vf = 1'b1;
				if (ph_n != bsp_pkg::PH_IDLE) begin
					res_f = bsp_pkg::mk_err(bsp_pkg::ERR_TRUNCATED, dep(cnt_n));
				end else if (cnt_n != '0) begin
					res_f = bsp_pkg::mk_err(bsp_pkg::ERR_UNCLOSED, dep(cnt_n));
				end else begin
					res_f = bsp_pkg::mk_res(bsp_pkg::EV_OK, bsp_pkg::KIND_NONE,
						64'd0, 16'd0, 8'd0, 6'd0);
				end
			end
		end
	end

	always_comb begin
		bundle.n       = 2'({1'b0, va} + {1'b0, vb} + {1'b0, vf});
		bundle.slot[0] = va ? res_a : res_f;
		bundle.slot[1] = vb ? res_b : res_f;
		bundle.slot[2] = res_f;
		case (bundle.n)
			2'd1:    bundle.slot[0].last_of_run = 1'b1;
			2'd2:    bundle.slot[1].last_of_run = 1'b1;
			2'd3:    bundle.slot[2].last_of_run = 1'b1;
			default: bundle.slot[0].last_of_run = bundle.slot[0].last_of_run;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= bsp_pkg::PH_IDLE;
			cnt_q  <= '0;
			acc_q  <= '0;
			neg_q  <= 1'b0;
			len_q  <= '0;
			body_q <= '0;
			err_q  <= 1'b0;
		end else if (accept) begin
			if (s_tlast) begin
				ph_q   <= bsp_pkg::PH_IDLE;
				cnt_q  <= '0;
				acc_q  <= '0;
				neg_q  <= 1'b0;
				len_q  <= '0;
				body_q <= '0;
				err_q  <= 1'b0;
			end else begin
				ph_q   <= ph_n;
				cnt_q  <= cnt_n;
				acc_q  <= acc_n;
				neg_q  <= neg_n;
				len_q  <= len_n;
				body_q <= body_n;
				err_q  <= err_q | err_set;
			end
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [1:0] above;
		logic [1:0] below;
		if (i == 0) begin : g_head
			assign above      = new_top;
			assign below      = mark_q[1];
			assign cell_op[i] = (accept && stk_op != bsp_pkg::STK_HOLD)
				? bsp_pkg::CELL_ABOVE : bsp_pkg::CELL_HOLD;
		end else begin : g_body
			assign above = mark_q[i-1];
			if (i == STACK_DEPTH - 1) begin : g_tail
				assign below = mark_q[i];
			end else begin : g_mid
				assign below = mark_q[i+1];
			end
			assign cell_op[i] = !accept ? bsp_pkg::CELL_HOLD
				: (stk_op == bsp_pkg::STK_PUSH) ? bsp_pkg::CELL_ABOVE
				: (stk_op == bsp_pkg::STK_POP) ? bsp_pkg::CELL_BELOW
				: bsp_pkg::CELL_HOLD;
		end
		bsp_stack_cell u_cell (
			.clk        (clk),
			.op         (cell_op[i]),
			.from_above (above),
			.from_below (below),
			.mark_q     (mark_q[i])
		);
	end

	bsp_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && bundle.n != 2'd0),
		.bundle_in (bundle),
		.space     (q_space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {7'd0, out_res.nest_depth, out_res.error_code, out_res.body_byte,
		out_res.string_length, out_res.int_value};
	assign m_tuser = {out_res.value_kind, out_res.event_res};
	assign m_tlast = out_res.last_of_run;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == bsp_pkg::REG_MAX_STR_LEN) ? {16'd0, max_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= bsp_pkg::MAX_STR_LEN_RST;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == bsp_pkg::REG_MAX_STR_LEN) begin
			max_q <= pwdata[15:0];
		end
	end

endmodule

/* hdl/bsp_checker.sv */
// Port-level checks for the bencode stream parser, bound to the top level.
// Depends on bsp_pkg for event and kind codes.
module bsp_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [bsp_pkg::TDATA_W-1:0] m_tdata,
	input logic [bsp_pkg::TUSER_W-1:0] m_tuser,
	input logic                        m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_full_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3:0] == bsp_pkg::EV_ERROR |-> m_tdata[90:88] != bsp_pkg::ERR_NONE)
		else $error("error event without error code");

	a_ok_closes: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3:0] == bsp_pkg::EV_OK |-> m_tlast && m_tdata[96:91] == 6'd0)
		else $error("ok event not last or with open containers");

	a_byte_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[3:0] == bsp_pkg::EV_STR_BYTE
			|-> m_tuser[6:4] == bsp_pkg::KIND_STRING)
		else $error("string byte event with wrong kind");

endmodule

bind bencode_stream_parser bsp_checker u_bsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

/* verif/tb_bencode_stream_parser.sv */
// Self-checking testbench for bencode_stream_parser: feeds bencoded messages byte by byte
// and checks every parser event against a built-in model of the tokenizer.
// Depends on bsp_pkg and the bencode_stream_parser RTL only.
module tb_bencode_stream_parser;

	localparam int NEST_MAX = bsp_pkg::STACK_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam logic [2:0] MAX_LEN_ADDR = {bsp_pkg::REG_MAX_STR_LEN, 2'b00};

	typedef struct {
		logic [7:0] data;
		logic       last;
	} byte_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'd0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [bsp_pkg::TDATA_W-1:0] m_tdata;
	logic [bsp_pkg::TUSER_W-1:0] m_tuser;
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic pready;

	// parser model state
	logic [1:0]  mark_stk [NEST_MAX];
	int          open_cnt = 0;
	logic [2:0]  lex_st = bsp_pkg::PH_IDLE;
	logic [63:0] int_mag = 64'd0;
	logic        int_neg = 1'b0;
	int unsigned str_len = 0;
	int unsigned body_due = 0;
	logic        halted = 1'b0;
	logic [15:0] max_len_reg = bsp_pkg::MAX_STR_LEN_RST;

	bsp_pkg::res_t events_due [$];
	byte_item_t    bytes_q [$];
	logic [7:0]    msg_buf [$];

	int pushed_cnt = 0;
	int took_cnt = 0;
	int msg_cnt = 0;
	int checked_cnt = 0;
	int err_events = 0;
	int limits_cnt = 0;
	int fails = 0;
	int cycle_cnt = 0;

	logic in_took = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int burst_left = 0;
	logic calm = 1'b0;
	byte_item_t cur;

	bencode_stream_parser DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic flag(input string what, input logic [63:0] got, input logic [63:0] want);
		fails++;
		$display("MISMATCH %s: got %0h expected %0h at result %0d", what, got, want,
			checked_cnt);
	endtask

	// ---------------- parser model ----------------
	function automatic void post(input logic [3:0] ev, input logic [2:0] kind,
			input logic [63:0] ival, input logic [15:0] slen, input logic [7:0] bb,
			input logic [2:0] code);
		bsp_pkg::res_t r;
		r.event_res     = ev;
		r.value_kind    = kind;
		r.int_value     = ival;
		r.string_length = slen;
		r.body_byte     = bb;
		r.error_code    = code;
		r.nest_depth    = 6'(open_cnt);
		r.last_of_run   = 1'b0;
		events_due.push_back(r);
	endfunction

	function automatic void fault(input logic [2:0] code);
		post(bsp_pkg::EV_ERROR, bsp_pkg::KIND_NONE, 64'd0, 16'd0, 8'd0, code);
		halted = 1'b1;
	endfunction

	function automatic void clear_parse();
		foreach (mark_stk[i]) mark_stk[i] = 2'd0;
		open_cnt = 0;
		lex_st   = bsp_pkg::PH_IDLE;
		int_mag  = 64'd0;
		int_neg  = 1'b0;
		str_len  = 0;
		body_due = 0;
		halted   = 1'b0;
	endfunction

	function automatic void finish_value(input logic [2:0] kind, input logic [63:0] ival,
			input logic [15:0] slen);
		if (open_cnt == 0) begin
			post(bsp_pkg::EV_TOP_VAL, kind, ival, slen, 8'd0, bsp_pkg::ERR_NONE);
		end else if (mark_stk[open_cnt-1] == bsp_pkg::MARK_LIST) begin
			post(bsp_pkg::EV_LIST_ELT, kind, ival, slen, 8'd0, bsp_pkg::ERR_NONE);
		end else if (mark_stk[open_cnt-1] == bsp_pkg::MARK_VAL) begin
			mark_stk[open_cnt-1] = bsp_pkg::MARK_KEY;
			post(bsp_pkg::EV_DICT_VAL, kind, ival, slen, 8'd0, bsp_pkg::ERR_NONE);
		end else begin
			fault(bsp_pkg::ERR_SYNTAX);
		end
	endfunction

	function automatic void finish_string(input logic [15:0] slen);
		if (open_cnt > 0 && mark_stk[open_cnt-1] == bsp_pkg::MARK_KEY) begin
			mark_stk[open_cnt-1] = bsp_pkg::MARK_VAL;
			post(bsp_pkg::EV_KEY, bsp_pkg::KIND_STRING, 64'd0, slen, 8'd0,
				bsp_pkg::ERR_NONE);
		end else begin
			finish_value(bsp_pkg::KIND_STRING, 64'd0, slen);
		end
	endfunction

	function automatic void open_level(input logic [1:0] mark, input logic [3:0] ev,
			input logic [2:0] kind);
		if (open_cnt >= NEST_MAX) begin
			fault(bsp_pkg::ERR_TOO_DEEP);
		end else begin
			mark_stk[open_cnt] = mark;
			open_cnt++;
			post(ev, kind, 64'd0, 16'd0, 8'd0, bsp_pkg::ERR_NONE);
		end
	endfunction

	function automatic void close_level();
		if (open_cnt == 0) begin
			fault(bsp_pkg::ERR_SYNTAX);
		end else if (mark_stk[open_cnt-1] == bsp_pkg::MARK_LIST) begin
			open_cnt--;
			mark_stk[open_cnt] = 2'd0;
			post(bsp_pkg::EV_LIST_END, bsp_pkg::KIND_LIST, 64'd0, 16'd0, 8'd0,
				bsp_pkg::ERR_NONE);
			finish_value(bsp_pkg::KIND_LIST, 64'd0, 16'd0);
		end else if (mark_stk[open_cnt-1] == bsp_pkg::MARK_KEY) begin
			open_cnt--;
			mark_stk[open_cnt] = 2'd0;
			post(bsp_pkg::EV_DICT_END, bsp_pkg::KIND_DICT, 64'd0, 16'd0, 8'd0,
				bsp_pkg::ERR_NONE);
			finish_value(bsp_pkg::KIND_DICT, 64'd0, 16'd0);
		end else begin
			fault(bsp_pkg::ERR_SYNTAX);
		end
	endfunction

	function automatic void scan_byte(input logic [7:0] b);
		logic       dig;
		logic [3:0] d;
		dig = (b >= bsp_pkg::CH_ZERO && b <= bsp_pkg::CH_NINE);
		d = dig ? 4'(b - bsp_pkg::CH_ZERO) : 4'd0;
		case (lex_st)
			bsp_pkg::PH_IDLE: begin
				if (b == bsp_pkg::CH_I) begin
					lex_st  = bsp_pkg::PH_INT_OPEN;
					int_mag = 64'd0;
					int_neg = 1'b0;
				end else if (dig) begin
					lex_st  = bsp_pkg::PH_STR_LEN;
					str_len = d;
				end else if (b == bsp_pkg::CH_L) begin
					open_level(bsp_pkg::MARK_LIST, bsp_pkg::EV_LIST_START,
						bsp_pkg::KIND_LIST);
				end else if (b == bsp_pkg::CH_D) begin
					open_level(bsp_pkg::MARK_KEY, bsp_pkg::EV_DICT_START,
						bsp_pkg::KIND_DICT);
				end else if (b == bsp_pkg::CH_E) begin
					close_level();
				end else begin
					fault(bsp_pkg::ERR_SYNTAX);
				end
			end
			bsp_pkg::PH_INT_OPEN, bsp_pkg::PH_INT_SIGN: begin
				if (lex_st == bsp_pkg::PH_INT_OPEN && b == bsp_pkg::CH_MINUS) begin
					int_neg = 1'b1;
					lex_st  = bsp_pkg::PH_INT_SIGN;
				end else if (dig) begin
					int_mag = 64'(d);
					lex_st  = bsp_pkg::PH_INT_DIG;
				end else begin
					fault(bsp_pkg::ERR_BAD_CHAR);
				end
			end
			bsp_pkg::PH_INT_DIG: begin
				if (dig) begin
					if (int_mag > bsp_pkg::INT_LIM
							|| (int_mag == bsp_pkg::INT_LIM && d > 4'd7))
						fault(bsp_pkg::ERR_OVERFLOW);
					else
						int_mag = int_mag * 64'd10 + 64'(d);
				end else if (b == bsp_pkg::CH_E) begin
					lex_st = bsp_pkg::PH_IDLE;
					finish_value(bsp_pkg::KIND_INT, int_neg ? 64'd0 - int_mag : int_mag,
						16'd0);
				end else begin
					fault(bsp_pkg::ERR_BAD_CHAR);
				end
			end
			bsp_pkg::PH_STR_LEN: begin
				if (dig) begin
					str_len = str_len * 10 + d;
					if (str_len > 32'h10000)
						str_len = 32'h10000;
				end else if (b == bsp_pkg::CH_COLON) begin
					if (str_len > max_len_reg) begin
						fault(bsp_pkg::ERR_TOO_LONG);
					end else if (str_len == 0) begin
						lex_st = bsp_pkg::PH_IDLE;
						finish_string(16'd0);
					end else begin
						body_due = str_len;
						lex_st   = bsp_pkg::PH_STR_BODY;
					end
				end else begin
					fault(bsp_pkg::ERR_BAD_CHAR);
				end
			end
			bsp_pkg::PH_STR_BODY: begin
				post(bsp_pkg::EV_STR_BYTE, bsp_pkg::KIND_STRING, 64'd0, 16'd0, b,
					bsp_pkg::ERR_NONE);
				if (body_due > 0)
					body_due--;
				if (body_due == 0) begin
					lex_st = bsp_pkg::PH_IDLE;
					finish_string(16'(str_len));
				end
			end
			default: begin
				lex_st = bsp_pkg::PH_IDLE;
				fault(bsp_pkg::ERR_SYNTAX);
			end
		endcase
	endfunction

	function automatic void parse_byte(input logic [7:0] b, input logic fin);
		int            base;
		bsp_pkg::res_t r;
		base = events_due.size();
		if (!halted) begin
			scan_byte(b);
			if (fin && !halted) begin
				if (lex_st != bsp_pkg::PH_IDLE)
					fault(bsp_pkg::ERR_TRUNCATED);
				else if (open_cnt > 0)
					fault(bsp_pkg::ERR_UNCLOSED);
				else
					post(bsp_pkg::EV_OK, bsp_pkg::KIND_NONE, 64'd0, 16'd0, 8'd0,
						bsp_pkg::ERR_NONE);
			end
		end
		if (fin)
			clear_parse();
		if (events_due.size() > base) begin
			r = events_due.pop_back();
			r.last_of_run = 1'b1;
			events_due.push_back(r);
		end
	endfunction

	task automatic check_result();
		bsp_pkg::res_t want;
		if (events_due.size() == 0) begin
			flag("unexpected result, event", 64'(m_tuser[3:0]), 64'd0);
		end else begin
			want = events_due.pop_front();
			if (m_tuser[3:0] !== want.event_res)
				flag("event_res", 64'(m_tuser[3:0]), 64'(want.event_res));
			if (m_tuser[6:4] !== want.value_kind)
				flag("value_kind", 64'(m_tuser[6:4]), 64'(want.value_kind));
			if (m_tdata[63:0] !== want.int_value)
				flag("int_value", m_tdata[63:0], want.int_value);
			if (m_tdata[79:64] !== want.string_length)
				flag("string_length", 64'(m_tdata[79:64]), 64'(want.string_length));
			if (m_tdata[87:80] !== want.body_byte)
				flag("body_byte", 64'(m_tdata[87:80]), 64'(want.body_byte));
			if (m_tdata[90:88] !== want.error_code)
				flag("error_code", 64'(m_tdata[90:88]), 64'(want.error_code));
			if (m_tdata[96:91] !== want.nest_depth)
				flag("nest_depth", 64'(m_tdata[96:91]), 64'(want.nest_depth));
			if (m_tlast !== want.last_of_run)
				flag("last_of_run", 64'(m_tlast), 64'(want.last_of_run));
			if (want.event_res == bsp_pkg::EV_ERROR)
				err_events++;
		end
		checked_cnt++;
	endtask

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (psel && penable && pwrite && pready && paddr == MAX_LEN_ADDR)
				max_len_reg = pwdata[15:0];
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tlast);
				took_cnt++;
			end
		end
		in_took <= arst_n && s_tvalid && s_tready;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_cnt);
			$display("Some tests failed");
			$finish;
		end
	end

	// ---------------- driver ----------------
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (burst_left == 0) begin
				calm = ($urandom_range(0, 3) == 0);
				burst_left = $urandom_range(20, 80);
			end else begin
				burst_left--;
			end
			if (in_took)
				send_gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
			if (!s_tvalid || in_took) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (bytes_q.size() > 0) begin
					cur = bytes_q.pop_front();
					s_tdata  <= cur.data;
					s_tlast  <= cur.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				stall_left = pick_gap();
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------- stimulus ----------------
	function automatic void add_text(input string s);
		for (int k = 0; k < s.len(); k++)
			msg_buf.push_back(s[k]);
	endfunction

	function automatic void commit();
		byte_item_t it;
		foreach (msg_buf[i]) begin
			it.data = msg_buf[i];
			it.last = (i == msg_buf.size() - 1);
			bytes_q.push_back(it);
		end
		pushed_cnt += msg_buf.size();
		msg_cnt++;
		msg_buf.delete();
	endfunction

	function automatic void put_int();
		logic [63:0] mag;
		int          r;
		msg_buf.push_back(bsp_pkg::CH_I);
		if ($urandom_range(0, 2) == 0)
			msg_buf.push_back(bsp_pkg::CH_MINUS);
		if ($urandom_range(0, 9) == 0)
			msg_buf.push_back(bsp_pkg::CH_ZERO);
		r = $urandom_range(0, 99);
		if (r < 60) begin
			mag = 64'($urandom_range(0, 999));
		end else if (r < 85) begin
			mag = {$urandom, $urandom} >> $urandom_range(1, 63);
		end else begin
			case ($urandom_range(0, 2))
				0: mag = 64'h7FFF_FFFF_FFFF_FFFF;
				1: mag = 64'h8000_0000_0000_0000;
				default: mag = 64'hFFFF_FFFF_FFFF_FFFF;
			endcase
		end
		add_text($sformatf("%0d", mag));
		msg_buf.push_back(bsp_pkg::CH_E);
	endfunction

	function automatic void put_str();
		int len;
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			len = $urandom_range(0, 4);
		else if (r < 97)
			len = $urandom_range(5, 20);
		else
			len = $urandom_range(200, 300);
		if ($urandom_range(0, 9) == 0)
			msg_buf.push_back(bsp_pkg::CH_ZERO);
		add_text($sformatf("%0d", len));
		msg_buf.push_back(bsp_pkg::CH_COLON);
		// an over-long prefix kills the message at the colon; keep the tail short
		if (len > max_len_reg)
			len = 2;
		repeat (len) msg_buf.push_back(8'($urandom));
	endfunction

	function automatic void put_value(input int lvl);
		int r;
		int n;
		r = $urandom_range(0, 9);
		if (lvl >= 3 && r >= 6)
			r = r - 6;
		if (r < 3) begin
			put_int();
		end else if (r < 6) begin
			put_str();
		end else if (r < 8) begin
			msg_buf.push_back(bsp_pkg::CH_L);
			n = $urandom_range(0, 3);
			repeat (n) put_value(lvl + 1);
			msg_buf.push_back(bsp_pkg::CH_E);
		end else begin
			msg_buf.push_back(bsp_pkg::CH_D);
			n = $urandom_range(0, 3);
			repeat (n) begin
				put_str();
				put_value(lvl + 1);
			end
			msg_buf.push_back(bsp_pkg::CH_E);
		end
	endfunction

	// returns how many bytes of the message the parser actually works on
	function automatic int build_msg();
		int r;
		int n;
		int pos;
		msg_buf.delete();
		r = $urandom_range(0, 99);
		if (r < 5) begin
			n = $urandom_range(1, 6);
			repeat (n) msg_buf.push_back(8'($urandom));
			return 1;
		end
		put_value(0);
		if ($urandom_range(0, 6) == 0)
			put_value(0);
		n = msg_buf.size();
		if (r >= 82) begin
			pos = $urandom_range(0, n - 1);
			case ($urandom_range(0, 2))
				0: msg_buf[pos] = 8'($urandom);
				1: while (msg_buf.size() > pos + 1) void'(msg_buf.pop_back());
				default: msg_buf[pos] = bsp_pkg::CH_E;
			endcase
			return pos + 1;
		end
		return n;
	endfunction

	task automatic drain();
		while (took_cnt != pushed_cnt || events_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic settle();
		drain();
		repeat (8) @(posedge clk);
	endtask

	task automatic set_max_len(input logic [15:0] v);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = MAX_LEN_ADDR;
		pwdata  = {16'($urandom), v};
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		limits_cnt++;
	endtask

	task automatic random_msgs(input int target);
		int counted;
		counted = 0;
		while (counted < target) begin
			counted += build_msg();
			commit();
			if ($urandom_range(0, 7) == 0)
				drain();
		end
	endtask

	initial begin
		foreach (mark_stk[i]) mark_stk[i] = 2'd0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		add_text("0:"); commit();
		add_text("le"); commit();
		add_text("e"); commit();
		add_text("i-e"); msg_buf.push_back(8'h00); commit();
		add_text("ie"); commit();
		add_text("d0:e"); commit();
		add_text("di1e"); commit();
		add_text("i1"); commit();
		add_text("l"); commit();
		msg_buf.push_back(8'hFF); commit();
		add_text("1"); msg_buf.push_back(8'h80); commit();
		random_msgs(110);
		settle();

		set_max_len(16'd3);
		add_text("3:abc"); commit();
		add_text("4:abcd"); commit();
		random_msgs(35);
		settle();

		set_max_len(16'd0);
		random_msgs(25);
		settle();

		set_max_len(16'hFFFF);
		add_text("65536:"); commit();
		add_text("99999999:"); commit();
		repeat (NEST_MAX) msg_buf.push_back(bsp_pkg::CH_L);
		repeat (NEST_MAX) msg_buf.push_back(bsp_pkg::CH_E);
		commit();
		repeat (NEST_MAX - 1) msg_buf.push_back(bsp_pkg::CH_L);
		add_text("d0:d");
		commit();
		random_msgs(35);
		settle();

		set_max_len(16'($urandom_range(1, 300)));
		random_msgs(35);
		drain();
		repeat (10) @(posedge clk);

		if (events_due.size() != 0)
			flag("results never delivered", 64'(events_due.size()), 64'd0);
		$display("Run covered %0d bytes in %0d messages under %0d string limits.",
			took_cnt, msg_cnt, limits_cnt + 1);
		$display("Checked %0d result items, %0d of them parser errors, in %0d cycles.",
			checked_cnt, err_events, cycle_cnt);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
